// ===== design/cle_pkg.sv =====
// Shared sizes, command and status codes, and controller/datapath interface types.
package cle_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ROTATE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SEEK      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                latch_in;
    logic                scan_inc;
    logic                link_tail_wr;
    logic                place;
    logic                place_front;
    logic                walk_init;
    logic                walk_step;
    logic                remove_apply;
    logic                rotate_apply;
    logic                seek_apply;
    logic                set_pos;
    logic                load_result;
  } cle_cmd_t;

  typedef struct packed {
    logic idx_busy;
    logic empty;
    logic full;
    logic hit;
    logic last;
    logic out_free;
  } cle_sts_t;

endpackage

// ===== design/cle_ram.sv =====
// Generic simple dual-port RAM with registered read.
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/cle_datapath.sv =====
// Datapath: slot memories, pointers, occupancy map, walk registers and result register.
module cle_datapath
  import cle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cle_cmd_t               c,
  output cle_sts_t               sts,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [VALUE_W-1:0]  value_in;
  logic [SLOT_W-1:0]   head;
  logic [SLOT_W-1:0]   tail;
  logic [CNT_W-1:0]    count;
  logic [CAPACITY-1:0] occ;
  logic [SLOT_W-1:0]   idx;
  logic [SLOT_W-1:0]   p;
  logic [SLOT_W-1:0]   q;
  logic [SLOT_W-1:0]   k;
  logic [STATUS_W-1:0] status_r;
  logic [SLOT_W-1:0]   pos_r;

  logic [SLOT_W-1:0]   raddr;
  logic [VALUE_W-1:0]  value_rdata;
  logic [SLOT_W-1:0]   link_rdata;
  logic                link_we;
  logic [SLOT_W-1:0]   link_waddr;
  logic [SLOT_W-1:0]   link_wdata;

  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_pos;
  logic [COUNT_W-1:0]  out_count;
  logic [VALUE_W-1:0]  out_front;

  assign raddr = c.walk_step ? link_rdata : head;

  assign link_we    = c.link_tail_wr | c.place | (c.remove_apply & (count != CNT_W'(1)));
  assign link_waddr = c.place ? idx : tail;

  always_comb begin
    if (c.link_tail_wr) begin
      link_wdata = idx;
    end else if (c.remove_apply) begin
      link_wdata = link_rdata;
    end else if (count == '0) begin
      link_wdata = idx;
    end else begin
      link_wdata = head;
    end
  end

  cle_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (c.place),
    .waddr (idx),
    .wdata (value_in),
    .raddr (raddr),
    .rdata (value_rdata)
  );

  cle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (raddr),
    .rdata (link_rdata)
  );

  assign sts.idx_busy = occ[idx];
  assign sts.empty    = (count == '0);
  assign sts.full     = (count == CNT_W'(CAPACITY));
  assign sts.hit      = (value_rdata == value_in);
  assign sts.last     = ((CNT_W'(k) + CNT_W'(1)) == count);
  assign sts.out_free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      occ      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (c.place) begin
        occ[idx] <= 1'b1;
        count    <= count + CNT_W'(1);
        if (count == '0) begin
          head <= idx;
          tail <= idx;
        end else if (c.place_front) begin
          head <= idx;
        end else begin
          tail <= idx;
        end
      end
      if (c.remove_apply) begin
        occ[head] <= 1'b0;
        count     <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          head <= '0;
          tail <= '0;
        end else begin
          head <= link_rdata;
        end
      end
      if (c.rotate_apply) begin
        tail <= head;
        head <= link_rdata;
      end
      if (c.seek_apply) begin
        head <= p;
        tail <= q;
      end
      if (c.load_result) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign out_status = status_r;
  assign out_pos    = POS_W'(pos_r);
  assign out_count  = COUNT_W'(count);
  assign out_front  = (count != '0) ? value_rdata : '0;

  always_ff @(posedge clk) begin
    if (c.latch_in) begin
      value_in <= s_tdata;
      idx      <= '0;
      pos_r    <= '0;
    end
    if (c.set_status) begin
      status_r <= c.status_code;
    end
    if (c.scan_inc) begin
      idx <= idx + SLOT_W'(1);
    end
    if (c.walk_init) begin
      p <= head;
      q <= tail;
      k <= '0;
    end
    if (c.walk_step) begin
      p <= link_rdata;
      q <= p;
      k <= k + SLOT_W'(1);
    end
    if (c.set_pos) begin
      pos_r <= k;
    end
    if (c.load_result) begin
      m_tdata <= {1'b0, out_front, out_count, out_pos, out_status};
    end
  end

endmodule

// ===== design/cle_ctrl.sv =====
// Controller: command sequencer driving the list datapath.
module cle_ctrl
  import cle_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [CMD_W-1:0] s_tuser,
  input  cle_sts_t         sts,
  output cle_cmd_t         c
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_LINK, S_WRITE, S_LOAD, S_STEP, S_WALK, S_FRONT, S_DONE
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CMD_W-1:0] cmd;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    c          = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          c.latch_in    = 1'b1;
          c.set_status  = 1'b1;
          c.status_code = ST_OK;
          state_next    = S_FRONT;
          if (s_tuser == CMD_INS_FRONT || s_tuser == CMD_INS_BACK) begin
            if (sts.full) begin
              c.status_code = ST_FULL;
            end else begin
              state_next = S_SCAN;
            end
          end else if (s_tuser inside {CMD_REMOVE, CMD_SEARCH, CMD_ROTATE, CMD_SEEK}) begin
            if (sts.empty) begin
              c.status_code = ST_EMPTY;
            end else begin
              state_next = S_LOAD;
            end
          end
        end
      end
      S_SCAN: begin
        if (sts.idx_busy) begin
          c.scan_inc = 1'b1;
        end else begin
          state_next = sts.empty ? S_WRITE : S_LINK;
        end
      end
      S_LINK: begin
        c.link_tail_wr = 1'b1;
        state_next     = S_WRITE;
      end
      S_WRITE: begin
        c.place       = 1'b1;
        c.place_front = (cmd == CMD_INS_FRONT);
        state_next    = S_FRONT;
      end
      S_LOAD: begin
        c.walk_init = 1'b1;
        state_next  = (cmd == CMD_REMOVE || cmd == CMD_ROTATE) ? S_STEP : S_WALK;
      end
      S_STEP: begin
        c.remove_apply = (cmd == CMD_REMOVE);
        c.rotate_apply = (cmd == CMD_ROTATE);
        state_next     = S_FRONT;
      end
      S_WALK: begin
        if (sts.hit) begin
          c.set_pos    = 1'b1;
          c.seek_apply = (cmd == CMD_SEEK);
          state_next   = S_FRONT;
        end else if (sts.last) begin
          c.set_status  = 1'b1;
          c.status_code = ST_MISSING;
          state_next    = S_FRONT;
        end else begin
          c.walk_step = 1'b1;
        end
      end
      S_FRONT: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          c.load_result = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
      if (c.latch_in) begin
        cmd <= s_tuser;
      end
    end
  end

endmodule

// ===== design/circular_list_engine.sv =====
// Top level of the circular list engine: controller, datapath and checks.
//
// Commands arrive on the s_ stream: s_tuser carries the command code, s_tdata the
// signed 32-bit value. Each command yields exactly one transfer on the m_ stream
// carrying status, position, element count and front value.
// The block works on one command at a time; s_tready is high only while idle.
// The time from input transfer to result valid is set by the slot scan and list
// walk; the walk makes one slot-memory read per cycle. Steps per command:
//   insert:            scan for the lowest free slot, link the old tail to it
//                      (skipped into an empty list), then write the slot
//   remove, rotate:    load the head, then unlink or rotate it
//   search, seek:      walk from the head until a match or the last element
//   rejected/empty:    status set directly, with no scan or walk
// The next command can be taken in the cycle after a result is loaded.
// The result sits in an output register; a stalled receiver holds it there and
// the next command is taken meanwhile, its result waiting until the register frees.
// Reset (rst, synchronous) empties the list at once; no clearing pass is needed.
module circular_list_engine
  import cle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // value[31:0]
  input  logic [CMD_W-1:0]       s_tuser,   // command[2:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // status[1:0], position[7:2], count[14:8],
                                            // front_value[46:15], zero[47]
);

  cle_cmd_t c;
  cle_sts_t sts;

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .c        (c)
  );

  cle_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .c        (c),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef NO_ASSERTIONS
  a_place_free_slot: assert property (@(posedge clk) disable iff (rst)
    c.place |-> !sts.idx_busy)
    else $error("insert writes an occupied slot");

  a_walk_no_overrun: assert property (@(posedge clk) disable iff (rst)
    c.walk_step |-> (!sts.hit && !sts.last))
    else $error("walk advances past a match or the last element");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second command taken while one is in progress");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    c.load_result && (c.status_code == ST_FULL || !c.set_status) && sts.full
    |=> (m_tdata[14:8] == COUNT_W'(CAPACITY)))
    else $error("full list reports wrong count");
`endif

endmodule
